FILE: rtl/core/integer_dct_8x8_forward_core_defines.svh
// Assertion helpers for the DCT core. Both expect aclk and aresetn in scope.
`ifndef INTEGER_DCT_8X8_FORWARD_CORE_DEFINES_SVH
`define INTEGER_DCT_8X8_FORWARD_CORE_DEFINES_SVH

// same-cycle implication
`define DCTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DCTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dctf_pkg.sv
package dctf_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int STORE_BITS = 16;
    localparam int COEF_BITS  = 12;
    localparam int ACC_BITS   = 36;
    localparam int SCL_BITS   = 28;

    typedef logic signed [STORE_BITS-1:0] smp_t;
    typedef logic signed [ACC_BITS-1:0]   acc_t;
    typedef logic signed [COEF_BITS-1:0]  coef_t;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] pix_0;
        logic signed [PIXEL_BITS-1:0] pix_1;
        logic signed [PIXEL_BITS-1:0] pix_2;
        logic signed [PIXEL_BITS-1:0] pix_3;
        logic signed [PIXEL_BITS-1:0] pix_4;
        logic signed [PIXEL_BITS-1:0] pix_5;
        logic signed [PIXEL_BITS-1:0] pix_6;
        logic signed [PIXEL_BITS-1:0] pix_7;
    } pix_row_t;

    typedef struct packed {
        logic [2:0] horiz_freq;
        coef_t      coef_0;
        coef_t      coef_1;
        coef_t      coef_2;
        coef_t      coef_3;
        coef_t      coef_4;
        coef_t      coef_5;
        coef_t      coef_6;
        coef_t      coef_7;
        logic       block_done;
    } coef_col_t;

    // row as queued between front and back
    typedef struct packed {
        pix_row_t   pix;
        logic [2:0] row;
        logic       last;
    } row_item_t;

    // tag carried alongside the transform pipeline
    typedef struct packed {
        logic       vld;
        logic       is_col;
        logic [2:0] idx;
    } bf_tag_t;

    typedef enum logic [1:0] {
        BK_ROWS,
        BK_DRAIN,
        BK_COLS
    } back_state_t;

    localparam logic signed [31:0] KM_C1   = 32'sd1004;
    localparam logic signed [31:0] KM_U2   = -32'sd1204;
    localparam logic signed [31:0] KM_U1   = -32'sd804;
    localparam logic signed [31:0] KM_C3   = 32'sd851;
    localparam logic signed [31:0] KM_U3   = -32'sd1420;
    localparam logic signed [31:0] KM_U0   = -32'sd282;
    localparam logic signed [31:0] KM_R2C6 = 32'sd554;
    localparam logic signed [31:0] KM_W7   = -32'sd1891;
    localparam logic signed [31:0] KM_W8   = 32'sd783;
    localparam acc_t K_R2    = 36'sd181;
    localparam acc_t RND_DC  = 36'sd16;
    localparam acc_t RND_AC  = 36'sd16384;
    localparam acc_t RND_ODD = 36'sd8192;
    localparam acc_t SMP_MAX = 36'sd32767;
    localparam acc_t SMP_MIN = -36'sd32768;
    localparam acc_t CF_MAX  = 36'sd2047;
    localparam acc_t CF_MIN  = -36'sd2048;

    function automatic smp_t sat_store(acc_t v);
        smp_t r;
        if (v > SMP_MAX) begin
            r = smp_t'(SMP_MAX);
        end else if (v < SMP_MIN) begin
            r = smp_t'(SMP_MIN);
        end else begin
            r = smp_t'(v);
        end
        return r;
    endfunction

    function automatic coef_t sat_coef(acc_t v);
        coef_t r;
        if (v > CF_MAX) begin
            r = coef_t'(CF_MAX);
        end else if (v < CF_MIN) begin
            r = coef_t'(CF_MIN);
        end else begin
            r = coef_t'(v);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/integer_dct_8x8_forward_core.sv
// Forward 8x8 integer DCT. After a block's eighth row is transferred, the row pass
// finishes, the transform pipeline drains and the column pass feeds the result queue;
// the eight results then follow one per cycle while m_ready is high. Rows are taken
// one per cycle while the back is in its row pass; a block costs 8 row issues, the
// transform pipeline drain and 8 column reads through one shared 1-D unit.
// Reset (aresetn, synchronous, active low) empties both queues and restarts at row 0.
module integer_dct_8x8_forward_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    // row transfers in
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dctf_pkg::pix_row_t   s_data,
    // coefficient column transfers out
    output logic                 m_valid,
    input  logic                 m_ready,
    output dctf_pkg::coef_col_t  m_data
);
    import dctf_pkg::*;

    // front: two-entry row queue tagged with the row index within the block
    logic      q_valid;
    logic      q_ready;
    row_item_t q_item;

    dctf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // back: row pass into the skewed transpose store, then the column pass
    // through the same four-stage 1-D transform, into an eight-entry result queue
    dctf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/core/dctf_front.sv
module dctf_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dctf_pkg::pix_row_t   s_data,
    output logic                 q_valid,
    input  logic                 q_ready,
    output dctf_pkg::row_item_t  q_item
);
    import dctf_pkg::*;

    row_item_t  buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] row_reg, row_next;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = buf_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        row_next    = push ? row_reg + 3'd1 : row_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            row_reg    <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            row_reg    <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= '{pix: s_data, row: row_reg, last: (row_reg == 3'd7)};
        end
    end

endmodule

FILE: rtl/core/dctf_bfly.sv
module dctf_bfly (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dctf_pkg::bf_tag_t        in_tag,
    input  dctf_pkg::smp_t [7:0]     in_smp,
    output dctf_pkg::bf_tag_t        out_tag,
    output dctf_pkg::acc_t [7:0]     out_val,
    output logic                     busy
);
    import dctf_pkg::*;

    // stage 1: butterflies
    logic signed [16:0] e [4];
    logic signed [16:0] o [4];
    bf_tag_t            tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic signed [17:0] p_reg, q_reg, r_reg, t_reg, s12_reg, s03_reg;
    logic signed [16:0] o_reg [4];
    logic signed [18:0] stq_reg;
    logic signed [17:0] p_next, q_next, r_next, t_next;

    // stage 2: products
    logic signed [31:0] m1_reg, m2_reg, m3_reg;
    logic signed [31:0] pu0_reg, pu1_reg, pu2_reg, pu3_reg, pw7_reg, pw8_reg;
    logic signed [18:0] f0_reg, f4_reg;

    // stage 3: sums
    logic signed [32:0] u0, u1, u2, u3, w7, w8;
    acc_t [7:0]         f_reg, f_next;

    // stage 4: scaling
    logic signed [SCL_BITS-1:0] h3, h5;
    acc_t                       g3, g5;
    acc_t [7:0]                 v_reg, v_next;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            e[i] = 17'(in_smp[i]) + 17'(in_smp[7-i]);
            o[i] = 17'(in_smp[i]) - 17'(in_smp[7-i]);
        end
        p_next = 18'(e[0]) + 18'(e[3]);
        q_next = 18'(e[0]) - 18'(e[3]);
        r_next = 18'(e[1]) + 18'(e[2]);
        t_next = 18'(e[1]) - 18'(e[2]);
    end

    always_comb begin
        u2 = 33'(pu2_reg) + 33'(m1_reg);
        u1 = 33'(pu1_reg) + 33'(m1_reg);
        u3 = 33'(pu3_reg) + 33'(m2_reg);
        u0 = 33'(pu0_reg) + 33'(m2_reg);
        w7 = 33'(pw7_reg) + 33'(m3_reg);
        w8 = 33'(pw8_reg) + 33'(m3_reg);
        f_next[0] = acc_t'(f0_reg);
        f_next[4] = acc_t'(f4_reg);
        f_next[2] = acc_t'(w8);
        f_next[6] = acc_t'(w7);
        f_next[1] = (acc_t'(u3) + acc_t'(u1)) + (acc_t'(u0) + acc_t'(u2));
        f_next[7] = (acc_t'(u3) + acc_t'(u1)) - (acc_t'(u0) + acc_t'(u2));
        f_next[3] = acc_t'(u3) - acc_t'(u1);
        f_next[5] = acc_t'(u0) - acc_t'(u2);
    end

    // rows: >>10 on odd/even AC, *181 >>17 on 3 and 5; columns: rounded variants
    always_comb begin
        h3 = SCL_BITS'(tag3_reg.is_col ? (f_reg[3] >>> 8) : f_reg[3]);
        h5 = SCL_BITS'(tag3_reg.is_col ? (f_reg[5] >>> 8) : f_reg[5]);
        g3 = acc_t'(h3) * K_R2;
        g5 = acc_t'(h5) * K_R2;
        if (tag3_reg.is_col) begin
            v_next[0] = (f_reg[0] + RND_DC) >>> 3;
            v_next[4] = (f_reg[4] + RND_DC) >>> 3;
            v_next[1] = (f_reg[1] + RND_AC) >>> 13;
            v_next[2] = (f_reg[2] + RND_AC) >>> 13;
            v_next[6] = (f_reg[6] + RND_AC) >>> 13;
            v_next[7] = (f_reg[7] + RND_AC) >>> 13;
            v_next[3] = (g3 + RND_ODD) >>> 12;
            v_next[5] = (g5 + RND_ODD) >>> 12;
        end else begin
            v_next[0] = f_reg[0];
            v_next[4] = f_reg[4];
            v_next[1] = f_reg[1] >>> 10;
            v_next[2] = f_reg[2] >>> 10;
            v_next[6] = f_reg[6] >>> 10;
            v_next[7] = f_reg[7] >>> 10;
            v_next[3] = g3 >>> 17;
            v_next[5] = g5 >>> 17;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg   <= p_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        t_reg   <= t_next;
        for (int i = 0; i < 4; i++) begin
            o_reg[i] <= o[i];
        end
        s12_reg <= 18'(o[1]) + 18'(o[2]);
        s03_reg <= 18'(o[0]) + 18'(o[3]);
        stq_reg <= 19'(t_next) + 19'(q_next);

        m1_reg  <= 32'(s12_reg) * KM_C1;
        m2_reg  <= 32'(s03_reg) * KM_C3;
        m3_reg  <= 32'(stq_reg) * KM_R2C6;
        pu0_reg <= 32'(o_reg[0]) * KM_U0;
        pu1_reg <= 32'(o_reg[1]) * KM_U1;
        pu2_reg <= 32'(o_reg[2]) * KM_U2;
        pu3_reg <= 32'(o_reg[3]) * KM_U3;
        pw7_reg <= 32'(t_reg) * KM_W7;
        pw8_reg <= 32'(q_reg) * KM_W8;
        f0_reg  <= 19'(p_reg) + 19'(r_reg);
        f4_reg  <= 19'(p_reg) - 19'(r_reg);

        f_reg   <= f_next;
        v_reg   <= v_next;
    end

    assign out_tag = tag4_reg;
    assign out_val = v_reg;
    assign busy    = tag1_reg.vld || tag2_reg.vld || tag3_reg.vld || tag4_reg.vld;

endmodule

FILE: rtl/core/dctf_back.sv
module dctf_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  dctf_pkg::row_item_t  q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dctf_pkg::coef_col_t  m_data
);
    import dctf_pkg::*;
    `include "integer_dct_8x8_forward_core_defines.svh"

    back_state_t state_reg, state_next;
    logic [2:0]  col_reg, col_next;
    logic        row_take;

    logic        row_vld_reg;
    pix_row_t    row_pix_reg;
    logic [2:0]  row_idx_reg;
    smp_t [7:0]  row_smp;

    // skewed transpose store: bank (row + col) mod 8, address row
    smp_t        mem [8][8];
    logic        rd_vld_reg;
    logic [2:0]  rd_k_reg;
    smp_t [7:0]  rd_data_reg;

    bf_tag_t     bf_in_tag, bf_out_tag;
    smp_t [7:0]  bf_in_smp;
    acc_t [7:0]  bf_out_val;
    logic        bf_busy;

    coef_col_t   ofifo [8];
    logic [2:0]  wp_reg, rp_reg;
    logic [3:0]  cnt_reg;
    logic        push, pop;
    coef_col_t   push_data;

    assign q_ready  = (state_reg == BK_ROWS);
    assign row_take = q_valid && q_ready;

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        unique case (state_reg)
            BK_ROWS: begin
                if (row_take && q_item.last) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (!bf_busy && !row_vld_reg && cnt_reg == 4'd0) begin
                    state_next = BK_COLS;
                    col_next   = 3'd0;
                end
            end
            BK_COLS: begin
                col_next = col_reg + 3'd1;
                if (col_reg == 3'd7) begin
                    state_next = BK_ROWS;
                end
            end
            default: state_next = BK_ROWS;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_ROWS;
            col_reg     <= 3'd0;
            row_vld_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_vld_reg <= row_take;
            rd_vld_reg  <= (state_reg == BK_COLS);
        end
    end

    always_ff @(posedge aclk) begin
        if (row_take) begin
            row_pix_reg <= q_item.pix;
            row_idx_reg <= q_item.row;
        end
        if (state_reg == BK_COLS) begin
            rd_k_reg <= col_reg;
            for (int b = 0; b < 8; b++) begin
                rd_data_reg[b] <= mem[b][3'(3'(b) - col_reg)];
            end
        end
        if (bf_out_tag.vld && !bf_out_tag.is_col) begin
            for (int b = 0; b < 8; b++) begin
                mem[b][bf_out_tag.idx] <= sat_store(bf_out_val[3'(3'(b) - bf_out_tag.idx)]);
            end
        end
    end

    always_comb begin
        row_smp[0] = smp_t'(row_pix_reg.pix_0);
        row_smp[1] = smp_t'(row_pix_reg.pix_1);
        row_smp[2] = smp_t'(row_pix_reg.pix_2);
        row_smp[3] = smp_t'(row_pix_reg.pix_3);
        row_smp[4] = smp_t'(row_pix_reg.pix_4);
        row_smp[5] = smp_t'(row_pix_reg.pix_5);
        row_smp[6] = smp_t'(row_pix_reg.pix_6);
        row_smp[7] = smp_t'(row_pix_reg.pix_7);
        for (int v = 0; v < 8; v++) begin
            bf_in_smp[v] = rd_vld_reg ? rd_data_reg[3'(3'(v) + rd_k_reg)] : row_smp[v];
        end
        bf_in_tag.vld    = row_vld_reg || rd_vld_reg;
        bf_in_tag.is_col = rd_vld_reg;
        bf_in_tag.idx    = rd_vld_reg ? rd_k_reg : row_idx_reg;
    end

    dctf_bfly u_bfly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_tag  (bf_in_tag),
        .in_smp  (bf_in_smp),
        .out_tag (bf_out_tag),
        .out_val (bf_out_val),
        .busy    (bf_busy)
    );

    // result queue; column pass starts only once it is empty
    assign push    = bf_out_tag.vld && bf_out_tag.is_col;
    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != 4'd0);
    assign m_data  = ofifo[rp_reg];

    always_comb begin
        push_data.horiz_freq = bf_out_tag.idx;
        push_data.coef_0     = sat_coef(bf_out_val[0]);
        push_data.coef_1     = sat_coef(bf_out_val[1]);
        push_data.coef_2     = sat_coef(bf_out_val[2]);
        push_data.coef_3     = sat_coef(bf_out_val[3]);
        push_data.coef_4     = sat_coef(bf_out_val[4]);
        push_data.coef_5     = sat_coef(bf_out_val[5]);
        push_data.coef_6     = sat_coef(bf_out_val[6]);
        push_data.coef_7     = sat_coef(bf_out_val[7]);
        push_data.block_done = (bf_out_tag.idx == 3'd7);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 3'd0;
            rp_reg  <= 3'd0;
            cnt_reg <= 4'd0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 3'd1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 3'd1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 4'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ofifo[wp_reg] <= push_data;
        end
    end

    `DCTF_ASSERT_NOW(a_ofifo_room, push, cnt_reg != 4'd8, "result queue overflow")
    `DCTF_ASSERT_NOW(a_one_source, rd_vld_reg, !row_vld_reg, "row and column issue collide")
    `DCTF_ASSERT_NEXT(a_cols_clean, state_reg == BK_DRAIN && state_next == BK_COLS, !bf_busy && cnt_reg == 4'd0, "column pass started with work in flight")

endmodule
